FILE: src/fts_pkg.sv
// Shared types, codes and defaults of the fence-tracking job scheduler.
`timescale 1ns / 1ps
`default_nettype none
package fts_pkg;

    localparam int DEF_NUM_CLIENTS = 16;
    localparam int DEF_NUM_QUEUES  = 4;
    localparam int DEF_FIFO_DEPTH  = 8;

    localparam logic [31:0] SEQ_MAX = 32'hFFFF_FFFF;

    localparam logic [2:0] CMD_SUBMIT   = 3'd0;
    localparam logic [2:0] CMD_COMPLETE = 3'd1;
    localparam logic [2:0] CMD_QUERY    = 3'd2;
    localparam logic [2:0] CMD_ASSIGN   = 3'd3;
    localparam logic [2:0] CMD_GONE     = 3'd4;

    localparam logic [1:0] KIND_ACK   = 2'd0;
    localparam logic [1:0] KIND_KICK  = 2'd1;
    localparam logic [1:0] KIND_QUERY = 2'd2;

    localparam logic [1:0] ST_OK   = 2'd0;
    localparam logic [1:0] ST_FULL = 2'd1;
    localparam logic [1:0] ST_IDLE = 2'd2;
    localparam logic [1:0] ST_BUSY = 2'd3;

    typedef struct packed {
        logic [2:0]  cmd;
        logic [3:0]  client;
        logic [1:0]  queue;
        logic [31:0] job_tag;
        logic [31:0] fence_gen;
        logic [31:0] fence_seqno;
        logic        job_failed;
    } cmd_t;

    typedef struct packed {
        logic [1:0]  kind;
        logic [1:0]  status;
        logic [1:0]  out_queue;
        logic [3:0]  out_client;
        logic [31:0] out_seqno;
        logic [31:0] out_gen;
        logic [31:0] out_tag;
        logic        signaled;
        logic        fence_error;
        logic        last;
    } res_t;

    function automatic res_t mk_res(
        input logic [1:0]  kind,
        input logic [1:0]  status,
        input logic [1:0]  q,
        input logic [3:0]  c,
        input logic [31:0] seq,
        input logic [31:0] gen,
        input logic [31:0] tag,
        input logic        sig,
        input logic        err,
        input logic        last
    );
        res_t r;
        r.kind        = kind;
        r.status      = status;
        r.out_queue   = q;
        r.out_client  = c;
        r.out_seqno   = seq;
        r.out_gen     = gen;
        r.out_tag     = tag;
        r.signaled    = sig;
        r.fence_error = err;
        r.last        = last;
        return r;
    endfunction

endpackage
`default_nettype wire

FILE: src/fts_alu.sv
// Shared 32-bit increment and compare unit used by the sequencer.
`timescale 1ns / 1ps
`default_nettype none
module fts_alu
(
    input  wire logic [31:0] a,
    input  wire logic [31:0] b,
    output logic      [31:0] sum,
    output logic             lt,
    output logic             eq
);
    assign sum = a + 32'd1;
    assign lt  = (a < b);
    assign eq  = (a == b);
endmodule
`default_nettype wire

FILE: src/fts_obuf.sv
// Output register of the result channel.
`timescale 1ns / 1ps
`default_nettype none
module fts_obuf
(
    input  wire logic           clk,
    input  wire logic           rst_n,
    input  wire logic           push_valid,
    input  wire fts_pkg::res_t  push_data,
    output logic                push_ready,
    output logic                m_tvalid,
    input  wire logic           m_tready,
    output logic [111:0]        m_tdata,  // status, out_queue, out_client, out_seqno,
                                          // out_gen, out_tag, signaled, fence_error, pad
    output logic [1:0]          m_tuser,  // kind
    output logic                m_tlast
);
    import fts_pkg::*;

    logic valid_reg;
    res_t data_reg;

    assign push_ready = !valid_reg || m_tready;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg <= 1'b0;
        end
        else if (push_ready)
        begin
            valid_reg <= push_valid;
        end
    end

    always_ff @(posedge clk)
    begin
        if (push_valid && push_ready)
        begin
            data_reg <= push_data;
        end
    end

    assign m_tvalid = valid_reg;
    assign m_tuser  = data_reg.kind;
    assign m_tlast  = data_reg.last;
    assign m_tdata  = {6'd0, data_reg.fence_error, data_reg.signaled, data_reg.out_tag,
                       data_reg.out_gen, data_reg.out_seqno, data_reg.out_client,
                       data_reg.out_queue, data_reg.status};
endmodule
`default_nettype wire

FILE: src/fts_core.sv
// Command sequencer, per-slot state, row table and job store.
`timescale 1ns / 1ps
`default_nettype none
module fts_core #(
    parameter int NUM_CLIENTS = fts_pkg::DEF_NUM_CLIENTS,
    parameter int NUM_QUEUES  = fts_pkg::DEF_NUM_QUEUES,
    parameter int FIFO_DEPTH  = fts_pkg::DEF_FIFO_DEPTH
)
(
    input  wire logic          clk,
    input  wire logic          rst_n,
    input  wire logic          in_valid,
    output logic               in_ready,
    input  wire fts_pkg::cmd_t in_cmd,
    output logic               res_valid,
    input  wire logic          res_ready,
    output fts_pkg::res_t      res_data
);
    import fts_pkg::*;

    localparam int CW   = (NUM_CLIENTS > 1) ? $clog2(NUM_CLIENTS) : 1;
    localparam int QW   = (NUM_QUEUES > 1) ? $clog2(NUM_QUEUES) : 1;
    localparam int PW   = $clog2(FIFO_DEPTH);
    localparam int CNTW = $clog2(FIFO_DEPTH + 1);
    localparam int NC2  = 1 << CW;
    localparam int NQ2  = 1 << QW;
    localparam int RAW  = CW + QW;
    localparam int JAW  = QW + CW + PW;

    typedef struct packed {
        logic [31:0]     issue_seq;
        logic [31:0]     done_seq;
        logic [31:0]     flush_seq;
        logic [PW-1:0]   rd_ptr;
        logic [CNTW-1:0] cnt;
    } row_t;

    typedef struct packed {
        logic [2:0]  q;
        logic [31:0] seq;
    } err_t;

    typedef enum logic [14:0] {
        S_IDLE  = 15'h0001,
        S_DEC   = 15'h0002,
        S_SUB   = 15'h0004,
        S_CMP   = 15'h0008,
        S_Q0    = 15'h0010,
        S_Q1    = 15'h0020,
        S_Q2    = 15'h0040,
        S_ASG   = 15'h0080,
        S_GRD   = 15'h0100,
        S_GEX   = 15'h0200,
        S_SCAN  = 15'h0400,
        S_KROW  = 15'h0800,
        S_KJOB  = 15'h1000,
        S_PACK  = 15'h2000,
        S_PKICK = 15'h4000
    } state_t;

    state_t state_reg, state_next;
    cmd_t   in_reg;
    res_t   ack_reg, kick_reg;
    logic   kick_pend_reg;
    logic [CW-1:0] idx_reg, scan_n_reg;
    logic [QW-1:0] gi_reg;
    logic   gen_match_reg, seq_lt_reg;

    logic          act_valid_reg  [NQ2];
    logic [CW-1:0] act_client_reg [NQ2];
    logic [63:0]   act_job_reg    [NQ2];
    logic [CW-1:0] rr_reg         [NQ2];
    logic [NC2-1:0] nonempty_reg  [NQ2];
    logic [31:0]   gen_reg        [NC2];
    err_t          err_reg        [NC2];
    logic          live_reg       [NC2];
    logic [(1<<RAW)-1:0] row_valid_reg;

    row_t        row_mem [1<<RAW];
    row_t        row_q;
    logic        row_vq;
    logic [63:0] job_mem [1<<JAW];
    logic [63:0] job_q;

    logic           row_re, row_we, job_re, job_we;
    logic [RAW-1:0] row_raddr, row_waddr;
    row_t           row_wdata, row_rd;
    logic [JAW-1:0] job_raddr, job_waddr;
    logic [63:0]    job_wdata;

    logic [31:0] alu_a, alu_b, alu_sum;
    logic        alu_lt, alu_eq;

    logic [CW-1:0] ci, act_slot, idx_inc;
    logic [QW-1:0] qi;
    logic          cok, qok;
    logic          sub_fail, cmp_flush, cmp_err, asg_busy, gex_act, gex_upd;
    logic [31:0]   act_seq, cmp_seq, gen_c;
    logic [PW:0]   posw;
    logic [PW-1:0] pos, rd_inc;

    fts_alu u_alu
    (
        .a   (alu_a),
        .b   (alu_b),
        .sum (alu_sum),
        .lt  (alu_lt),
        .eq  (alu_eq)
    );

    assign ci       = CW'(in_reg.client);
    assign qi       = QW'(in_reg.queue);
    assign cok      = (32'(in_reg.client) < 32'(NUM_CLIENTS));
    assign qok      = (32'(in_reg.queue) < 32'(NUM_QUEUES));
    assign row_rd   = row_vq ? row_q : '0;
    assign act_slot = act_client_reg[qi];
    assign act_seq  = act_job_reg[qi][31:0];
    assign gen_c    = cok ? gen_reg[ci] : 32'd0;

    assign sub_fail = !cok || !qok || (row_rd.cnt == CNTW'(FIFO_DEPTH)) || alu_eq;
    assign posw     = (PW+1)'(row_rd.rd_ptr) + (PW+1)'(row_rd.cnt);
    assign pos      = (posw >= (PW+1)'(FIFO_DEPTH)) ? PW'(posw - (PW+1)'(FIFO_DEPTH))
                                                    : PW'(posw);
    assign rd_inc   = (row_rd.rd_ptr == PW'(FIFO_DEPTH - 1)) ? '0 : row_rd.rd_ptr + 1'b1;
    assign idx_inc  = (idx_reg == CW'(NUM_CLIENTS - 1)) ? '0 : idx_reg + 1'b1;

    // a dead slot whose flush mark is past the job completes the flush mark instead
    assign cmp_flush = !live_reg[act_slot] && alu_lt;
    assign cmp_seq   = cmp_flush ? row_rd.flush_seq : act_seq;
    assign cmp_err   = in_reg.job_failed | cmp_flush;

    assign gex_act = act_valid_reg[gi_reg] && (act_client_reg[gi_reg] == ci);
    assign gex_upd = !gex_act && alu_lt;

    always_comb
    begin
        asg_busy = !cok;
        for (int i = 0; i < NQ2; i++)
        begin
            if ((act_valid_reg[i] && act_client_reg[i] == ci) || nonempty_reg[i][ci])
            begin
                asg_busy = 1'b1;
            end
        end
    end

    always_comb
    begin
        case (state_reg)
            S_SUB:   begin alu_a = row_rd.issue_seq; alu_b = SEQ_MAX;            end
            S_CMP:   begin alu_a = act_seq;          alu_b = row_rd.flush_seq;   end
            S_Q0:    begin alu_a = gen_reg[ci];      alu_b = in_reg.fence_gen;   end
            S_Q1:    begin alu_a = row_rd.done_seq;  alu_b = in_reg.fence_seqno; end
            S_Q2:    begin alu_a = err_reg[ci].seq;  alu_b = in_reg.fence_seqno; end
            S_ASG:   begin alu_a = gen_reg[ci];      alu_b = 32'd0;              end
            S_GEX:   begin alu_a = row_rd.done_seq;  alu_b = row_rd.issue_seq;   end
            default: begin alu_a = 32'd0;            alu_b = 32'd0;              end
        endcase
    end

    always_comb
    begin
        state_next = state_reg;
        in_ready   = 1'b0;
        res_valid  = 1'b0;
        res_data   = ack_reg;
        row_re     = 1'b0;
        row_raddr  = {ci, qi};
        row_we     = 1'b0;
        row_waddr  = {ci, qi};
        row_wdata  = row_rd;
        job_re     = 1'b0;
        job_raddr  = {qi, idx_reg, row_rd.rd_ptr};
        job_we     = 1'b0;
        job_waddr  = {qi, ci, pos};
        job_wdata  = {in_reg.job_tag, alu_sum};
        case (state_reg)
            S_IDLE:
            begin
                in_ready = 1'b1;
                if (in_valid)
                begin
                    state_next = S_DEC;
                end
            end
            S_DEC:
            begin
                case (in_reg.cmd)
                    CMD_SUBMIT:
                    begin
                        row_re     = 1'b1;
                        state_next = S_SUB;
                    end
                    CMD_COMPLETE:
                    begin
                        row_re     = 1'b1;
                        row_raddr  = {act_slot, qi};
                        state_next = S_CMP;
                    end
                    CMD_QUERY:
                    begin
                        row_re     = 1'b1;
                        state_next = S_Q0;
                    end
                    CMD_ASSIGN: state_next = S_ASG;
                    CMD_GONE:   state_next = cok ? S_GRD : S_PACK;
                    default:    state_next = S_IDLE;
                endcase
            end
            S_SUB:
            begin
                if (sub_fail)
                begin
                    state_next = S_PACK;
                end
                else
                begin
                    row_we              = 1'b1;
                    row_wdata.issue_seq = alu_sum;
                    row_wdata.cnt       = row_rd.cnt + 1'b1;
                    job_we              = 1'b1;
                    state_next          = act_valid_reg[qi] ? S_PACK : S_SCAN;
                end
            end
            S_CMP:
            begin
                if (!qok || !act_valid_reg[qi])
                begin
                    state_next = S_PACK;
                end
                else
                begin
                    row_we             = 1'b1;
                    row_waddr          = {act_slot, qi};
                    row_wdata.done_seq = cmp_seq;
                    state_next         = S_SCAN;
                end
            end
            S_Q0:  state_next = S_Q1;
            S_Q1:  state_next = S_Q2;
            S_Q2:  state_next = S_PACK;
            S_ASG: state_next = S_PACK;
            S_GRD:
            begin
                row_re     = 1'b1;
                row_raddr  = {ci, gi_reg};
                state_next = S_GEX;
            end
            S_GEX:
            begin
                row_we              = 1'b1;
                row_waddr           = {ci, gi_reg};
                row_wdata.flush_seq = row_rd.issue_seq;
                row_wdata.done_seq  = gex_upd ? row_rd.issue_seq : row_rd.done_seq;
                row_wdata.rd_ptr    = '0;
                row_wdata.cnt       = '0;
                state_next = (gi_reg == QW'(NUM_QUEUES - 1)) ? S_PACK : S_GRD;
            end
            S_SCAN:
            begin
                if (nonempty_reg[qi][idx_reg])
                begin
                    row_re     = 1'b1;
                    row_raddr  = {idx_reg, qi};
                    state_next = S_KROW;
                end
                else if (scan_n_reg == CW'(NUM_CLIENTS - 1))
                begin
                    state_next = S_PACK;
                end
            end
            S_KROW:
            begin
                job_re           = 1'b1;
                row_we           = 1'b1;
                row_waddr        = {idx_reg, qi};
                row_wdata.rd_ptr = rd_inc;
                row_wdata.cnt    = row_rd.cnt - 1'b1;
                state_next       = S_KJOB;
            end
            S_KJOB: state_next = S_PACK;
            S_PACK:
            begin
                res_valid = 1'b1;
                if (res_ready)
                begin
                    state_next = kick_pend_reg ? S_PKICK : S_IDLE;
                end
            end
            S_PKICK:
            begin
                res_valid = 1'b1;
                res_data  = kick_reg;
                if (res_ready)
                begin
                    state_next = S_IDLE;
                end
            end
            default: state_next = S_IDLE;
        endcase
    end

    always_ff @(posedge clk)
    begin
        if (row_we)
        begin
            row_mem[row_waddr] <= row_wdata;
        end
        if (row_re)
        begin
            row_q <= row_mem[row_raddr];
        end
        if (job_we)
        begin
            job_mem[job_waddr] <= job_wdata;
        end
        if (job_re)
        begin
            job_q <= job_mem[job_raddr];
        end
    end

    always_ff @(posedge clk)
    begin
        if (state_reg == S_IDLE && in_valid)
        begin
            in_reg <= in_cmd;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= S_IDLE;
            ack_reg       <= '0;
            kick_reg      <= '0;
            kick_pend_reg <= 1'b0;
            idx_reg       <= '0;
            scan_n_reg    <= '0;
            gi_reg        <= '0;
            gen_match_reg <= 1'b0;
            seq_lt_reg    <= 1'b0;
            row_vq        <= 1'b0;
            row_valid_reg <= '0;
            for (int i = 0; i < NQ2; i++)
            begin
                act_valid_reg[i]  <= 1'b0;
                act_client_reg[i] <= '0;
                act_job_reg[i]    <= '0;
                rr_reg[i]         <= '0;
                nonempty_reg[i]   <= '0;
            end
            for (int i = 0; i < NC2; i++)
            begin
                gen_reg[i]  <= '0;
                err_reg[i]  <= '0;
                live_reg[i] <= 1'b0;
            end
        end
        else
        begin
            state_reg <= state_next;
            if (row_re)
            begin
                row_vq <= row_valid_reg[row_raddr];
            end
            if (row_we)
            begin
                row_valid_reg[row_waddr] <= 1'b1;
            end
            case (state_reg)
                S_IDLE:
                begin
                    kick_pend_reg <= 1'b0;
                end
                S_DEC:
                begin
                    gi_reg <= '0;
                    if (in_reg.cmd == CMD_GONE && !cok)
                    begin
                        ack_reg <= mk_res(KIND_ACK, ST_OK, in_reg.queue, in_reg.client,
                                          32'd0, 32'd0, 32'd0, 1'b0, 1'b0, 1'b1);
                    end
                end
                S_SUB:
                begin
                    idx_reg    <= rr_reg[qi];
                    scan_n_reg <= '0;
                    if (sub_fail)
                    begin
                        ack_reg <= mk_res(KIND_ACK, ST_FULL, in_reg.queue, in_reg.client,
                                          32'd0, gen_c, 32'd0, 1'b0, 1'b0, 1'b1);
                    end
                    else
                    begin
                        nonempty_reg[qi][ci] <= 1'b1;
                        ack_reg <= mk_res(KIND_ACK, ST_OK, in_reg.queue, in_reg.client,
                                          alu_sum, gen_reg[ci], 32'd0, 1'b0, 1'b0,
                                          act_valid_reg[qi]);
                    end
                end
                S_CMP:
                begin
                    idx_reg    <= rr_reg[qi];
                    scan_n_reg <= '0;
                    if (!qok || !act_valid_reg[qi])
                    begin
                        ack_reg <= mk_res(KIND_ACK, ST_IDLE, in_reg.queue, in_reg.client,
                                          32'd0, 32'd0, 32'd0, 1'b0, 1'b0, 1'b1);
                    end
                    else
                    begin
                        act_valid_reg[qi] <= 1'b0;
                        if (cmp_err)
                        begin
                            err_reg[act_slot] <= {3'(in_reg.queue), cmp_seq};
                        end
                        ack_reg <= mk_res(KIND_ACK, ST_OK, in_reg.queue, 4'(act_slot),
                                          cmp_seq, gen_reg[act_slot], 32'd0, 1'b0, 1'b0,
                                          1'b0);
                    end
                end
                S_Q0:
                begin
                    gen_match_reg <= cok && qok && alu_eq;
                end
                S_Q1:
                begin
                    seq_lt_reg <= alu_lt;
                end
                S_Q2:
                begin
                    ack_reg <= mk_res(KIND_QUERY, ST_OK, in_reg.queue, in_reg.client,
                                      (cok && qok) ? row_rd.done_seq : 32'd0, gen_c, 32'd0,
                                      !(gen_match_reg && seq_lt_reg),
                                      gen_match_reg && !seq_lt_reg && (err_reg[ci] != '0) &&
                                      (err_reg[ci].q == 3'(in_reg.queue)) && !alu_lt,
                                      1'b1);
                end
                S_ASG:
                begin
                    if (asg_busy)
                    begin
                        ack_reg <= mk_res(KIND_ACK, ST_BUSY, in_reg.queue, in_reg.client,
                                          32'd0, gen_c, 32'd0, 1'b0, 1'b0, 1'b1);
                    end
                    else
                    begin
                        for (int i = 0; i < NQ2; i++)
                        begin
                            row_valid_reg[{ci, QW'(i)}] <= 1'b0;
                        end
                        err_reg[ci]  <= '0;
                        gen_reg[ci]  <= alu_sum;
                        live_reg[ci] <= 1'b1;
                        ack_reg <= mk_res(KIND_ACK, ST_OK, in_reg.queue, in_reg.client,
                                          32'd0, alu_sum, 32'd0, 1'b0, 1'b0, 1'b1);
                    end
                end
                S_GEX:
                begin
                    nonempty_reg[gi_reg][ci] <= 1'b0;
                    if (gex_upd)
                    begin
                        err_reg[ci] <= {3'(gi_reg), row_rd.issue_seq};
                    end
                    if (gi_reg == QW'(NUM_QUEUES - 1))
                    begin
                        live_reg[ci] <= 1'b0;
                        ack_reg <= mk_res(KIND_ACK, ST_OK, in_reg.queue, in_reg.client,
                                          32'd0, gen_reg[ci], 32'd0, 1'b0, 1'b0, 1'b1);
                    end
                    else
                    begin
                        gi_reg <= gi_reg + 1'b1;
                    end
                end
                S_SCAN:
                begin
                    if (!nonempty_reg[qi][idx_reg])
                    begin
                        if (scan_n_reg == CW'(NUM_CLIENTS - 1))
                        begin
                            ack_reg.last <= 1'b1;
                        end
                        else
                        begin
                            idx_reg    <= idx_inc;
                            scan_n_reg <= scan_n_reg + 1'b1;
                        end
                    end
                end
                S_KROW:
                begin
                    if (row_rd.cnt == CNTW'(1))
                    begin
                        nonempty_reg[qi][idx_reg] <= 1'b0;
                    end
                end
                S_KJOB:
                begin
                    act_valid_reg[qi]  <= 1'b1;
                    act_client_reg[qi] <= idx_reg;
                    act_job_reg[qi]    <= job_q;
                    rr_reg[qi]         <= idx_inc;
                    ack_reg.last       <= 1'b0;
                    kick_pend_reg      <= 1'b1;
                    kick_reg <= mk_res(KIND_KICK, ST_OK, in_reg.queue, 4'(idx_reg),
                                       job_q[31:0], gen_reg[idx_reg], job_q[63:32],
                                       1'b0, 1'b0, 1'b1);
                end
                default:
                begin
                end
            endcase
        end
    end
endmodule
`default_nettype wire

FILE: src/fence_tracking_job_scheduler.sv
// Top level of the fence-tracking job scheduler.
//
// Commands enter on the s_t* channel (cmd in s_tuser) and results leave on the
// m_t* channel (kind in m_tuser, m_tlast on the last result of a command).
// One command is handled at a time; s_tready is high only while the sequencer
// is idle, and drops for the whole of a command.
// Each command is decoded, then handled by the sequencer around the shared
// compare unit and the registered row table and job store: query: a row read,
// then generation, sequence and error compares; assign: a busy check and
// update; unknown command: no result; client gone: a row read and write per
// queue (none for a slot out of range); submit: a row and job write, with a
// scan only if the queue is idle; refused submit or complete: no scan;
// complete: a row read and write, then a scan, over every slot when nothing is
// left to start. The round-robin scan visits one client slot per cycle; a found
// job adds a row read and a job read. A kick follows its acknowledge once the
// output register has taken the acknowledge. A new command is taken in the
// cycle after the last result has entered the output register.
// Reset clears all queues, counters, slots and the round-robin pointers; no
// clearing pass is needed. If the receiver stalls, the output register holds
// its result and the sequencer waits with its next result.
`timescale 1ns / 1ps
`default_nettype none
module fence_tracking_job_scheduler #(
    parameter int NUM_CLIENTS = fts_pkg::DEF_NUM_CLIENTS,
    parameter int NUM_QUEUES  = fts_pkg::DEF_NUM_QUEUES,
    parameter int FIFO_DEPTH  = fts_pkg::DEF_FIFO_DEPTH
)
(
    input  wire logic         clk,
    input  wire logic         rst_n,
    input  wire logic         s_tvalid,
    output logic              s_tready,
    input  wire logic [103:0] s_tdata,  // client, queue, job_tag, fence_gen,
                                        // fence_seqno, job_failed, pad
    input  wire logic [2:0]   s_tuser,  // cmd
    output logic              m_tvalid,
    input  wire logic         m_tready,
    output logic [111:0]      m_tdata,  // status, out_queue, out_client, out_seqno,
                                        // out_gen, out_tag, signaled, fence_error, pad
    output logic [1:0]        m_tuser,  // kind
    output logic              m_tlast
);
    import fts_pkg::*;

    cmd_t in_cmd;
    res_t res_data;
    logic res_valid, res_ready;

    assign in_cmd.cmd         = s_tuser;
    assign in_cmd.client      = s_tdata[3:0];
    assign in_cmd.queue       = s_tdata[5:4];
    assign in_cmd.job_tag     = s_tdata[37:6];
    assign in_cmd.fence_gen   = s_tdata[69:38];
    assign in_cmd.fence_seqno = s_tdata[101:70];
    assign in_cmd.job_failed  = s_tdata[102];

    fts_core #(
        .NUM_CLIENTS (NUM_CLIENTS),
        .NUM_QUEUES  (NUM_QUEUES),
        .FIFO_DEPTH  (FIFO_DEPTH)
    ) u_core
    (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (s_tvalid),
        .in_ready  (s_tready),
        .in_cmd    (in_cmd),
        .res_valid (res_valid),
        .res_ready (res_ready),
        .res_data  (res_data)
    );

    fts_obuf u_obuf
    (
        .clk        (clk),
        .rst_n      (rst_n),
        .push_valid (res_valid),
        .push_data  (res_data),
        .push_ready (res_ready),
        .m_tvalid   (m_tvalid),
        .m_tready   (m_tready),
        .m_tdata    (m_tdata),
        .m_tuser    (m_tuser),
        .m_tlast    (m_tlast)
    );
endmodule
`default_nettype wire

FILE: src/fts_checker.sv
// Port-level checks of the scheduler, bound to the top level.
`timescale 1ns / 1ps
`default_nettype none
module fts_port_checks
(
    input wire logic       clk,
    input wire logic       rst_n,
    input wire logic       s_tvalid,
    input wire logic       s_tready,
    input wire logic       m_tvalid,
    input wire logic       m_tready,
    input wire logic [1:0] m_tuser,
    input wire logic       m_tlast
);
    import fts_pkg::*;

    // a stalled transaction stays offered
    a_hold: assert property (@(posedge clk) disable iff (!rst_n)
        m_tvalid && !m_tready |=> m_tvalid)
        else $error("result dropped while stalled");

    // one command at a time
    a_busy: assert property (@(posedge clk) disable iff (!rst_n)
        s_tvalid && s_tready |=> !s_tready)
        else $error("command taken while busy");

    a_kind: assert property (@(posedge clk) disable iff (!rst_n)
        m_tvalid |-> (m_tuser == KIND_ACK || m_tuser == KIND_KICK || m_tuser == KIND_QUERY))
        else $error("bad result kind");

    // kicks and query answers always close a command
    a_kick_last: assert property (@(posedge clk) disable iff (!rst_n)
        m_tvalid && (m_tuser == KIND_KICK || m_tuser == KIND_QUERY) |-> m_tlast)
        else $error("kick or query answer not last");
endmodule

bind fence_tracking_job_scheduler fts_port_checks u_fts_port_checks
(
    .clk      (clk),
    .rst_n    (rst_n),
    .s_tvalid (s_tvalid),
    .s_tready (s_tready),
    .m_tvalid (m_tvalid),
    .m_tready (m_tready),
    .m_tuser  (m_tuser),
    .m_tlast  (m_tlast)
);
`default_nettype wire

FILE: bench/fts_checker.sv
// Watches both channels of the job scheduler, predicts results and compares them.
`timescale 1ns / 1ps
module fts_checker
    import fts_pkg::*;
(
    input  logic                   clk,
    input  logic                   rst_n,
    input  logic                   s_tvalid,
    input  logic                   s_tready,
    input  logic [103:0]           s_tdata,
    input  logic [2:0]             s_tuser,
    input  logic                   m_tvalid,
    input  logic                   m_tready,
    input  logic [111:0]           m_tdata,
    input  logic [1:0]             m_tuser,
    input  logic                   m_tlast,
    output int                     errors,
    output int                     pending,
    output logic [15:0][31:0]      gen_view,
    output logic [15:0][3:0][31:0] issued_view
);

    logic [63:0] jobs [4][16][8];
    logic [2:0]  rd_ptr [4][16];
    logic [3:0]  fill [4][16];
    logic [3:0]  rr [4];
    bit          run_v [4];
    logic [3:0]  run_c [4];
    logic [63:0] run_j [4];
    logic [31:0] nseq [16][4];
    logic [31:0] cseq [16][4];
    logic [31:0] flush [16][4];
    logic [34:0] err_rec [16];
    logic [31:0] gen [16];
    bit          live [16];

    res_t expected_q[$];

    always_comb
    begin
        pending = expected_q.size();
        for (int c = 0; c < 16; c++)
        begin
            gen_view[c] = gen[c];
            for (int q = 0; q < 4; q++)
                issued_view[c][q] = nseq[c][q];
        end
    end

    task automatic push_res(logic [1:0] kind, logic [1:0] st, logic [1:0] q, logic [3:0] c,
                            logic [31:0] seq, logic [31:0] g, logic [31:0] tag,
                            logic sig, logic err);
        res_t r;
        r = '{kind, st, q, c, seq, g, tag, sig, err, 1'b0};
        expected_q.push_back(r);
    endtask

    // start the next job on an idle queue, scanning slots from the round-robin pointer
    task automatic kick_next(int q);
        int idx;
        logic [63:0] e;
        if (run_v[q])
            return;
        for (int i = 0; i < 16; i++)
        begin
            idx = (rr[q] + i) % 16;
            if (fill[q][idx] != 0)
            begin
                e = jobs[q][idx][rd_ptr[q][idx]];
                rd_ptr[q][idx] = rd_ptr[q][idx] + 3'd1;
                fill[q][idx] = fill[q][idx] - 4'd1;
                run_v[q] = 1;
                run_c[q] = idx[3:0];
                run_j[q] = e;
                rr[q] = (idx + 1) % 16;
                push_res(KIND_KICK, ST_OK, q[1:0], idx[3:0], e[31:0], gen[idx], e[63:32], 0, 0);
                return;
            end
        end
    endtask

    task automatic predict(logic [2:0] cmd, logic [103:0] d);
        logic [3:0]  c;
        logic [1:0]  q;
        logic [31:0] tag, fgen, fseq, seq;
        logic        failed, err, sig, busy;
        int          s;
        c = d[3:0];
        q = d[5:4];
        tag = d[37:6];
        fgen = d[69:38];
        fseq = d[101:70];
        failed = d[102];
        case (cmd)
            CMD_SUBMIT:
            begin
                if (fill[q][c] >= 8 || nseq[c][q] == SEQ_MAX)
                    push_res(KIND_ACK, ST_FULL, q, c, 0, gen[c], 0, 0, 0);
                else
                begin
                    seq = nseq[c][q] + 1;
                    nseq[c][q] = seq;
                    jobs[q][c][rd_ptr[q][c] + fill[q][c][2:0]] = {tag, seq};
                    fill[q][c] = fill[q][c] + 4'd1;
                    push_res(KIND_ACK, ST_OK, q, c, seq, gen[c], 0, 0, 0);
                    kick_next(q);
                end
            end
            CMD_COMPLETE:
            begin
                if (!run_v[q])
                    push_res(KIND_ACK, ST_IDLE, q, c, 0, 0, 0, 0, 0);
                else
                begin
                    s = run_c[q];
                    seq = run_j[q][31:0];
                    err = failed;
                    // a flushed client's job completes the flush mark instead
                    if (!live[s] && flush[s][q] > seq)
                    begin
                        seq = flush[s][q];
                        err = 1;
                    end
                    if (err)
                        err_rec[s] = {1'b0, q, seq};
                    cseq[s][q] = seq;
                    run_v[q] = 0;
                    push_res(KIND_ACK, ST_OK, q, s[3:0], seq, gen[s], 0, 0, 0);
                    kick_next(q);
                end
            end
            CMD_QUERY:
            begin
                sig = 1;
                err = 0;
                if (gen[c] == fgen && cseq[c][q] < fseq)
                    sig = 0;
                else if (gen[c] == fgen && err_rec[c] != 0 && err_rec[c][34:32] == q
                         && err_rec[c][31:0] >= fseq)
                    err = 1;
                push_res(KIND_QUERY, ST_OK, q, c, cseq[c][q], gen[c], 0, sig, err);
            end
            CMD_ASSIGN:
            begin
                busy = 0;
                for (int i = 0; i < 4; i++)
                    if ((run_v[i] && run_c[i] == c) || fill[i][c] != 0)
                        busy = 1;
                if (busy)
                    push_res(KIND_ACK, ST_BUSY, q, c, 0, gen[c], 0, 0, 0);
                else
                begin
                    for (int i = 0; i < 4; i++)
                    begin
                        cseq[c][i] = 0;
                        flush[c][i] = 0;
                        nseq[c][i] = 0;
                    end
                    err_rec[c] = 0;
                    gen[c] = gen[c] + 1;
                    live[c] = 1;
                    push_res(KIND_ACK, ST_OK, q, c, 0, gen[c], 0, 0, 0);
                end
            end
            CMD_GONE:
            begin
                for (int i = 0; i < 4; i++)
                begin
                    fill[i][c] = 0;
                    rd_ptr[i][c] = 0;
                    flush[c][i] = nseq[c][i];
                    if (!(run_v[i] && run_c[i] == c) && flush[c][i] > cseq[c][i])
                    begin
                        err_rec[c] = {i[2:0], flush[c][i]};
                        cseq[c][i] = flush[c][i];
                    end
                end
                live[c] = 0;
                push_res(KIND_ACK, ST_OK, q, c, 0, gen[c], 0, 0, 0);
            end
            default:
                return;
        endcase
        expected_q[expected_q.size() - 1].last = 1'b1;
    endtask

    always @(posedge clk or negedge rst_n)
    begin
        res_t got, want;
        if (!rst_n)
        begin
            errors = 0;
            expected_q.delete();
            for (int q = 0; q < 4; q++)
            begin
                rr[q] = 0;
                run_v[q] = 0;
                run_c[q] = 0;
                run_j[q] = 0;
                for (int c = 0; c < 16; c++)
                begin
                    rd_ptr[q][c] = 0;
                    fill[q][c] = 0;
                    nseq[c][q] = 0;
                    cseq[c][q] = 0;
                    flush[c][q] = 0;
                end
            end
            for (int c = 0; c < 16; c++)
            begin
                err_rec[c] = 0;
                gen[c] = 0;
                live[c] = 0;
            end
        end
        else
        begin
            if (s_tvalid && s_tready)
                predict(s_tuser, s_tdata);
            if (m_tvalid && m_tready)
            begin
                got = '{m_tuser, m_tdata[1:0], m_tdata[3:2], m_tdata[7:4], m_tdata[39:8],
                        m_tdata[71:40], m_tdata[103:72], m_tdata[104], m_tdata[105], m_tlast};
                if (expected_q.size() == 0)
                begin
                    errors++;
                    if (errors <= 10)
                        $display("ERROR: unexpected result %p", got);
                end
                else
                begin
                    want = expected_q.pop_front();
                    if (got !== want)
                    begin
                        errors++;
                        if (errors <= 10)
                            $display("ERROR: result mismatch\n  expected %p\n  actual   %p",
                                     want, got);
                    end
                end
            end
        end
    end

endmodule

FILE: bench/testbench.sv
// Stimulus and verdict for the fence-tracking job scheduler.
`timescale 1ns / 1ps
module testbench;
    import fts_pkg::*;

    logic                   clk;
    logic                   rst_n;
    logic                   s_tvalid;
    logic                   s_tready;
    logic [103:0]           s_tdata;   // client, queue, job_tag, fence_gen, fence_seqno,
                                       // job_failed, pad
    logic [2:0]             s_tuser;   // cmd
    logic                   m_tvalid;
    logic                   m_tready;
    logic [111:0]           m_tdata;   // status, out_queue, out_client, out_seqno, out_gen,
                                       // out_tag, signaled, fence_error, pad
    logic [1:0]             m_tuser;   // kind
    logic                   m_tlast;
    int                     errors;
    int                     pending;
    logic [15:0][31:0]      gen_view;
    logic [15:0][3:0][31:0] issued_view;
    int                     send_idle;
    int                     recv_stall;

    fence_tracking_job_scheduler u_top (.*);

    fts_checker u_check (.*);

    initial
    begin
        clk = 0;
        forever #5 clk = ~clk;
    end

    always @(negedge clk)
        m_tready = ($urandom_range(0, 99) >= recv_stall);

    task automatic send(logic [2:0] cmd, logic [3:0] c, logic [1:0] q, logic [31:0] tag,
                        logic [31:0] fgen, logic [31:0] fseq, logic failed);
        while ($urandom_range(0, 99) < send_idle)
        begin
            s_tvalid = 0;
            @(negedge clk);
        end
        s_tvalid = 1;
        s_tuser = cmd;
        s_tdata = {1'b0, failed, fseq, fgen, tag, q, c};
        @(posedge clk);
        while (!s_tready)
            @(posedge clk);
        @(negedge clk);
    endtask

    task automatic send_random();
        int          pick;
        logic [3:0]  c;
        logic [1:0]  q;
        logic [2:0]  cmd;
        logic [31:0] fgen, fseq;
        pick = $urandom_range(0, 99);
        c = $urandom_range(0, 15);
        q = $urandom_range(0, 3);
        if (pick < 36)
            cmd = CMD_SUBMIT;
        else if (pick < 66)
            cmd = CMD_COMPLETE;
        else if (pick < 86)
            cmd = CMD_QUERY;
        else if (pick < 93)
            cmd = CMD_ASSIGN;
        else if (pick < 97)
            cmd = CMD_GONE;
        else
            cmd = $urandom_range(5, 7);
        // most queries name a real fence near the slot's issued numbers
        fgen = ($urandom_range(0, 9) < 8) ? gen_view[c] : $urandom;
        fseq = ($urandom_range(0, 7) != 0) ? issued_view[c][q] - $urandom_range(0, 3) : $urandom;
        send(cmd, c, q, $urandom, fgen, fseq, $urandom_range(0, 3) == 0);
    endtask

    initial
    begin
        rst_n = 0;
        s_tvalid = 0;
        s_tdata = '0;
        s_tuser = '0;
        m_tready = 0;
        send_idle = 0;
        recv_stall = 0;
        repeat (4) @(posedge clk);
        @(negedge clk);
        rst_n = 1;

        send(CMD_ASSIGN, 4'd0, 2'd0, 0, 0, 0, 0);
        send(CMD_ASSIGN, 4'd15, 2'd3, 0, 0, 0, 0);
        // fill slot 0 queue 0: one runs, eight wait, the last is refused as full
        for (int i = 0; i < 10; i++)
            send(CMD_SUBMIT, 4'd0, 2'd0, (i == 0) ? 32'h0 : 32'hFFFF_FFFF - i, 0, 0, 0);
        send(CMD_QUERY, 4'd0, 2'd0, 0, 32'd1, 32'd1, 0);
        send(CMD_COMPLETE, 4'd0, 2'd0, 0, 0, 0, 1'b1);
        send(CMD_QUERY, 4'd0, 2'd0, 0, 32'd1, 32'd1, 0);
        send(CMD_COMPLETE, 4'd0, 2'd1, 0, 0, 0, 0);
        send(CMD_ASSIGN, 4'd0, 2'd2, 0, 0, 0, 0);
        send(CMD_SUBMIT, 4'd15, 2'd3, 32'hFFFF_FFFF, 0, 0, 0);
        send(CMD_GONE, 4'd0, 2'd0, 0, 0, 0, 0);
        send(CMD_COMPLETE, 4'd0, 2'd0, 0, 0, 0, 0);
        send(CMD_QUERY, 4'd0, 2'd0, 0, 32'd1, 32'hFFFF_FFFF, 0);
        send(CMD_QUERY, 4'd15, 2'd3, 0, 32'hFFFF_FFFF, 32'hFFFF_FFFF, 0);
        send(CMD_ASSIGN, 4'd0, 2'd0, 0, 0, 0, 0);
        send(3'd5, 4'd1, 2'd1, 0, 0, 0, 0);
        send(3'd6, 4'd2, 2'd2, 0, 0, 0, 0);
        send(3'd7, 4'd3, 2'd3, 0, 0, 0, 0);
        send(CMD_GONE, 4'd9, 2'd1, 0, 0, 0, 0);

        for (int n = 0; n < 1850; n++)
        begin
            case (n / 463)
                0: begin send_idle = 0;  recv_stall = 0;  end
                1: begin send_idle = 69; recv_stall = 0;  end
                2: begin send_idle = 0;  recv_stall = 69; end
                default: begin send_idle = 16; recv_stall = 16; end
            endcase
            // short runs of no idling inside every phase
            if ($urandom_range(0, 9) == 0)
            begin
                send_idle = 0;
                recv_stall = 0;
            end
            send_random();
        end
        s_tvalid = 0;
        recv_stall = 0;
        while (pending != 0)
            @(posedge clk);
        repeat (60) @(posedge clk);
        if (errors == 0)
            $display("Test completed successfully");
        else
            $display("Test completed with failures");
        $finish;
    end

    initial
    begin
        #5_000_000;
        $display("Test completed with failures");
        $finish;
    end

endmodule
